### hw/rtl/assert_macros.svh
// Assertion macros shared by the timer table RTL.
// Depends on nothing; files that check their own logic include it by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, masked while reset is asserted.
`define AST_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked property that must also hold through reset.
`define AST_CLK_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AST_CLK(lbl, clk, rst_n, prop, msg)
`define AST_CLK_NR(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/otmr_pkg.sv
// Shared types and codes for the one-shot timer table.
// No dependencies; used by otmr_cell, otmr_ctrl and the top level.
`timescale 1ns / 1ps
`default_nettype none

package otmr_pkg;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_CREATE = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CREATED = 3'd0,
		ST_INVALID = 3'd1,
		ST_FULL    = 3'd2,
		ST_DELETED = 3'd3,
		ST_EXPIRED = 3'd4,
		ST_TICKEND = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'd0,
		FSM_SCAN = 2'd1,
		FSM_END  = 2'd2
	} fsm_t;

	// Broadcast from the sequencer to every slot cell
	typedef struct packed {
		logic        scan_tick;
		logic        del_en;
		logic [31:0] tick_now;
		logic [31:0] wr_callback;
		logic [31:0] wr_arg;
		logic [31:0] wr_deadline;
	} cell_ctl_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  slot_index;
		logic [31:0] fired_callback;
		logic [31:0] fired_arg;
		logic [31:0] tick_now;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

### hw/rtl/one_shot_timer_table_core.sv
// Top level of the one-shot timer table: sequencer plus a row of slot cells.
// Depends on otmr_pkg, otmr_ctrl, otmr_cell and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// A command transfers at a rising edge with start high and busy low. Every
// result is shown for exactly one cycle with valid high and cannot be held
// off, so the receiver must take it on that edge. Results are registered:
// each shows in the cycle after the one that decided it. Delete and
// rejected create finish in the transfer cycle itself. A create walks the
// scan token from slot 0 to the lowest free slot, one slot a cycle, and
// ends with the full result when no slot is free. A tick walks the token
// over every slot, one slot a cycle, with at most one expiry result a
// cycle, then gives the tick-end result. The walk of the token along the
// cell row sets how long a create or a tick keeps busy high. slot_index
// carries the low four bits of the slot number. The tick counter wraps at
// 32 bits and deadlines compare unsigned against it.
module one_shot_timer_table_core #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  command,
	input  wire logic [31:0] callback_id,
	input  wire logic [31:0] user_arg,
	input  wire logic [31:0] deadline,
	input  wire logic [3:0]  slot_handle,
	output logic             valid,
	output logic [2:0]       status,
	output logic [3:0]       slot_index,
	output logic [31:0]      fired_callback,
	output logic [31:0]      fired_arg,
	output logic [31:0]      tick_now,
	output logic             last
);

	otmr_pkg::cell_ctl_t ctl;
	otmr_pkg::result_t   res;
	logic                launch;
	logic [NUM_SLOTS-1:0] tok_out;
	logic [NUM_SLOTS-1:0] hit;
	logic [NUM_SLOTS-1:0] del_sel;
	logic [31:0]          cell_cb  [NUM_SLOTS];
	logic [31:0]          cell_arg [NUM_SLOTS];
	logic                 any_hit;
	logic [31:0]          hit_callback;
	logic [31:0]          hit_arg;

	// Sequencer: decode commands, hold the tick counter, drive the scan
	otmr_ctrl #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.command      (command),
		.callback_id  (callback_id),
		.user_arg     (user_arg),
		.deadline     (deadline),
		.slot_handle  (slot_handle),
		.any_hit      (any_hit),
		.hit_callback (hit_callback),
		.hit_arg      (hit_arg),
		.busy         (busy),
		.launch       (launch),
		.ctl          (ctl),
		.valid        (valid),
		.res          (res)
	);

	// Row of slot cells; the token enters at slot 0 and moves right one
	// cell per cycle, so the scan visits slots in index order
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		// decode the delete handle against this slot's number
		assign del_sel[i] = ctl.del_en && ({3'b000, slot_handle} == 7'(i));

		otmr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.del_sel  (del_sel[i]),
			.tok_in   ((i == 0) ? launch : tok_out[(i == 0) ? 0 : i - 1]),
			.tok_out  (tok_out[i]),
			.hit      (hit[i]),
			.callback (cell_cb[i]),
			.arg      (cell_arg[i])
		);
	end

	// Only the token holder can hit, so an AND-OR gather picks its payload
	always_comb begin
		any_hit      = 1'b0;
		hit_callback = '0;
		hit_arg      = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			any_hit      = any_hit | hit[i];
			hit_callback = hit_callback | (hit[i] ? cell_cb[i] : 32'd0);
			hit_arg      = hit_arg | (hit[i] ? cell_arg[i] : 32'd0);
		end
	end

	// Drive the result ports from the registered result
	assign status         = res.status;
	assign slot_index     = res.slot_index;
	assign fired_callback = res.fired_callback;
	assign fired_arg      = res.fired_arg;
	assign tick_now       = res.tick_now;
	assign last           = res.last;

	`AST_CLK(a_single_hit, clk, arst_n, $onehot0(hit), "more than one slot hit in a cycle")
	`AST_CLK(a_single_token, clk, arst_n, $onehot0({tok_out, launch}), "scan token duplicated")

endmodule

`default_nettype wire

### hw/rtl/otmr_cell.sv
// One timer slot of the table: used flag, deadline, callback and argument.
// Passes the scan token to its right-hand neighbour. Depends on otmr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module otmr_cell (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire otmr_pkg::cell_ctl_t  ctl,
	input  wire logic                 del_sel,
	input  wire logic                 tok_in,
	output logic                      tok_out,
	output logic                      hit,
	output logic [31:0]               callback,
	output logic [31:0]               arg
);

	logic        tok_q;
	logic        used_q;
	logic [31:0] deadline_q;
	logic [31:0] callback_q;
	logic [31:0] arg_q;
	logic        expired;

	assign expired  = used_q && (ctl.tick_now >= deadline_q);
	assign hit      = tok_q && (ctl.scan_tick ? expired : !used_q);
	// a claiming create keeps the token here
	assign tok_out  = tok_q && !(hit && !ctl.scan_tick);
	assign callback = callback_q;
	assign arg      = arg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			used_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
			if (del_sel) begin
				used_q <= 1'b0;
			end else if (hit) begin
				used_q <= !ctl.scan_tick;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit && !ctl.scan_tick) begin
			deadline_q <= ctl.wr_deadline;
			callback_q <= ctl.wr_callback;
			arg_q      <= ctl.wr_arg;
		end
	end

	`AST_CLK(a_claim_sets_used, clk, arst_n, (hit && !ctl.scan_tick) |=> used_q, "claim lost")
	`AST_CLK(a_expiry_frees, clk, arst_n, (hit && ctl.scan_tick) |=> !used_q, "expiry kept slot")

endmodule

`default_nettype wire

### hw/rtl/otmr_ctrl.sv
// Command sequencer: tick counter, scan walk, result register.
// Depends on otmr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module otmr_ctrl #(
	parameter int NUM_SLOTS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [1:0]           command,
	input  wire logic [31:0]          callback_id,
	input  wire logic [31:0]          user_arg,
	input  wire logic [31:0]          deadline,
	input  wire logic [3:0]           slot_handle,
	input  wire logic                 any_hit,
	input  wire logic [31:0]          hit_callback,
	input  wire logic [31:0]          hit_arg,
	output logic                      busy,
	output logic                      launch,
	output otmr_pkg::cell_ctl_t       ctl,
	output logic                      valid,
	output otmr_pkg::result_t         res
);

	localparam int CW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [CW-1:0] LAST_IDX = CW'(NUM_SLOTS - 1);

	otmr_pkg::fsm_t    state_q, state_d;
	otmr_pkg::cmd_t    cmd;
	otmr_pkg::result_t res_d, res_q;
	logic              valid_d, valid_q;
	logic              del_en;
	logic              accept;
	logic              handle_oob;
	logic [CW-1:0]     cnt_q;
	logic [6:0]        cnt_ext;
	logic [31:0]       tick_q;
	logic              scan_tick_q;
	logic [31:0]       wr_callback_q;
	logic [31:0]       wr_arg_q;
	logic [31:0]       wr_deadline_q;

	assign cmd        = otmr_pkg::cmd_t'(command);
	assign busy       = (state_q != otmr_pkg::FSM_IDLE);
	assign accept     = start && !busy;
	assign handle_oob = ({3'b000, slot_handle} >= 7'(NUM_SLOTS));
	assign cnt_ext    = 7'(cnt_q);

	always_comb begin
		state_d          = state_q;
		res_d            = '0;
		res_d.tick_now   = tick_q;
		valid_d          = 1'b0;
		launch           = 1'b0;
		del_en           = 1'b0;
		case (state_q)
			otmr_pkg::FSM_IDLE: begin
				if (start) begin
					case (cmd)
						otmr_pkg::CMD_TICK: begin
							launch  = 1'b1;
							state_d = otmr_pkg::FSM_SCAN;
						end
						otmr_pkg::CMD_CREATE: begin
							if (callback_id == 32'd0 || deadline == 32'd0) begin
								valid_d      = 1'b1;
								res_d.status = otmr_pkg::ST_INVALID;
								res_d.last   = 1'b1;
							end else begin
								launch  = 1'b1;
								state_d = otmr_pkg::FSM_SCAN;
							end
						end
						otmr_pkg::CMD_DELETE: begin
							valid_d          = 1'b1;
							res_d.slot_index = slot_handle;
							res_d.last       = 1'b1;
							if (handle_oob) begin
								res_d.status = otmr_pkg::ST_INVALID;
							end else begin
								del_en       = 1'b1;
								res_d.status = otmr_pkg::ST_DELETED;
							end
						end
						default: ;
					endcase
				end
			end
			otmr_pkg::FSM_SCAN: begin
				res_d.slot_index = cnt_ext[3:0];
				if (scan_tick_q) begin
					if (any_hit) begin
						valid_d              = 1'b1;
						res_d.status         = otmr_pkg::ST_EXPIRED;
						res_d.fired_callback = hit_callback;
						res_d.fired_arg      = hit_arg;
					end
					if (cnt_q == LAST_IDX) begin
						state_d = otmr_pkg::FSM_END;
					end
				end else if (any_hit) begin
					valid_d      = 1'b1;
					res_d.status = otmr_pkg::ST_CREATED;
					res_d.last   = 1'b1;
					state_d      = otmr_pkg::FSM_IDLE;
				end else if (cnt_q == LAST_IDX) begin
					valid_d          = 1'b1;
					res_d.status     = otmr_pkg::ST_FULL;
					res_d.slot_index = 4'd0;
					res_d.last       = 1'b1;
					state_d          = otmr_pkg::FSM_IDLE;
				end
			end
			otmr_pkg::FSM_END: begin
				valid_d      = 1'b1;
				res_d.status = otmr_pkg::ST_TICKEND;
				res_d.last   = 1'b1;
				state_d      = otmr_pkg::FSM_IDLE;
			end
			default: begin
				state_d = otmr_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= otmr_pkg::FSM_IDLE;
			valid_q     <= 1'b0;
			cnt_q       <= '0;
			tick_q      <= '0;
			scan_tick_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
			if (state_q == otmr_pkg::FSM_SCAN) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (accept) begin
				scan_tick_q <= (cmd == otmr_pkg::CMD_TICK);
				if (cmd == otmr_pkg::CMD_TICK) begin
					tick_q <= tick_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			wr_callback_q <= callback_id;
			wr_arg_q      <= user_arg;
			wr_deadline_q <= deadline;
		end
	end

	assign ctl.scan_tick   = scan_tick_q;
	assign ctl.del_en      = del_en;
	assign ctl.tick_now    = tick_q;
	assign ctl.wr_callback = wr_callback_q;
	assign ctl.wr_arg      = wr_arg_q;
	assign ctl.wr_deadline = wr_deadline_q;
	assign valid           = valid_q;
	assign res             = res_q;

	`AST_CLK(a_tick_advances, clk, arst_n, (accept && cmd == otmr_pkg::CMD_TICK) |=> (tick_q == $past(tick_q) + 32'd1), "tick counter did not advance")
	`AST_CLK(a_claim_ends_scan, clk, arst_n, (state_q == otmr_pkg::FSM_SCAN && !scan_tick_q && any_hit) |=> (state_q == otmr_pkg::FSM_IDLE), "create scan ran on")
	`AST_CLK(a_last_when_idle, clk, arst_n, (valid_q && res_q.last) |-> (state_q == otmr_pkg::FSM_IDLE), "final result while still busy")

endmodule

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for one_shot_timer_table_core: a shadow of the timer table
// predicts every result, and a monitor compares each result as it comes out.
// Depends on otmr_pkg and on the RTL of the timer table.
`timescale 1ns / 1ps

module tb;

	localparam int SLOTS = 16;
	localparam int SETTLE_CYCLES = 2 * (SLOTS + 2) + 4;

	// Shadow copy of the timer table. Every transfer that is accepted goes in
	// here, and the results that the table must give come out in order.
	class timer_table_shadow;
		logic [31:0]        ticks;
		bit                 used[SLOTS];
		logic [31:0]        due[SLOTS];
		logic [31:0]        handler[SLOTS];
		logic [31:0]        payload[SLOTS];
		otmr_pkg::result_t  awaited[$];
		int                 failures;

		function new();
			ticks = '0;
			failures = 0;
			foreach (used[i]) used[i] = 1'b0;
		endfunction

		function void post(otmr_pkg::status_t s, int slot, logic [31:0] cb,
				logic [31:0] arg, logic fin);
			otmr_pkg::result_t r;
			r.status = s;
			r.slot_index = slot[3:0];
			r.fired_callback = cb;
			r.fired_arg = arg;
			r.tick_now = ticks;
			r.last = fin;
			awaited.push_back(r);
		endfunction

		// Apply one accepted command and queue the results that it causes
		function void take_command(otmr_pkg::cmd_t cmd, logic [31:0] cb, logic [31:0] arg,
				logic [31:0] dl, logic [3:0] h);
			int free_slot;
			free_slot = -1;
			case (cmd)
				otmr_pkg::CMD_TICK: begin
					ticks = ticks + 32'd1;
					for (int i = 0; i < SLOTS; i++) begin
						if (used[i] && ticks >= due[i]) begin
							post(otmr_pkg::ST_EXPIRED, i, handler[i], payload[i], 1'b0);
							used[i] = 1'b0;
						end
					end
					post(otmr_pkg::ST_TICKEND, 0, '0, '0, 1'b1);
				end
				otmr_pkg::CMD_CREATE: begin
					if (cb == '0 || dl == '0) begin
						post(otmr_pkg::ST_INVALID, 0, '0, '0, 1'b1);
					end else begin
						for (int i = SLOTS - 1; i >= 0; i--)
							if (!used[i]) free_slot = i;
						if (free_slot < 0) begin
							post(otmr_pkg::ST_FULL, 0, '0, '0, 1'b1);
						end else begin
							used[free_slot] = 1'b1;
							handler[free_slot] = cb;
							payload[free_slot] = arg;
							due[free_slot] = dl;
							post(otmr_pkg::ST_CREATED, free_slot, '0, '0, 1'b1);
						end
					end
				end
				otmr_pkg::CMD_DELETE: begin
					if (int'(h) >= SLOTS) begin
						post(otmr_pkg::ST_INVALID, int'(h), '0, '0, 1'b1);
					end else begin
						used[h] = 1'b0;
						post(otmr_pkg::ST_DELETED, int'(h), '0, '0, 1'b1);
					end
				end
				default: ;
			endcase
		endfunction

		function void note_failure(string what, otmr_pkg::result_t exp_r,
				otmr_pkg::result_t got);
			failures++;
			if (failures <= 10) begin
				$write("%t MISMATCH %s: expected st=%0d slot=%0d cb=%h arg=%h tick=%h last=%0d",
					$realtime, what, exp_r.status, exp_r.slot_index, exp_r.fired_callback,
					exp_r.fired_arg, exp_r.tick_now, exp_r.last);
				$display(", got st=%0d slot=%0d cb=%h arg=%h tick=%h last=%0d",
					got.status, got.slot_index, got.fired_callback, got.fired_arg,
					got.tick_now, got.last);
			end
		endfunction

		// Compare one result from the table with the oldest one awaited
		function void match_result(otmr_pkg::result_t got);
			otmr_pkg::result_t exp_r;
			if (awaited.size() == 0) begin
				exp_r = '0;
				note_failure("unexpected result", exp_r, got);
				return;
			end
			exp_r = awaited.pop_front();
			if (got.status !== exp_r.status || got.slot_index !== exp_r.slot_index ||
					got.fired_callback !== exp_r.fired_callback ||
					got.fired_arg !== exp_r.fired_arg ||
					got.tick_now !== exp_r.tick_now || got.last !== exp_r.last)
				note_failure("field", exp_r, got);
		endfunction

		// Pick a slot that holds a timer, or any slot when none does
		function logic [3:0] some_used_slot();
			int picks[$];
			for (int i = 0; i < SLOTS; i++)
				if (used[i]) picks.push_back(i);
			if (picks.size() == 0)
				return 4'($urandom_range(0, SLOTS - 1));
			return 4'(picks[$urandom_range(0, picks.size() - 1)]);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [1:0]  command = 2'd0;
	logic [31:0] callback_id = '0;
	logic [31:0] user_arg = '0;
	logic [31:0] deadline = '0;
	logic [3:0]  slot_handle = '0;
	wire         busy;
	wire         valid;
	wire [2:0]   status;
	wire [3:0]   slot_index;
	wire [31:0]  fired_callback;
	wire [31:0]  fired_arg;
	wire [31:0]  tick_now;
	wire         last;

	timer_table_shadow shadow = new();
	int issued;

	one_shot_timer_table_core #(.NUM_SLOTS(SLOTS)) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.command        (command),
		.callback_id    (callback_id),
		.user_arg       (user_arg),
		.deadline       (deadline),
		.slot_handle    (slot_handle),
		.valid          (valid),
		.status         (status),
		.slot_index     (slot_index),
		.fired_callback (fired_callback),
		.fired_arg      (fired_arg),
		.tick_now       (tick_now),
		.last           (last)
	);

	always #10 clk = ~clk;

	// Take every strobed result at the edge that ends its cycle; the values
	// read here are those from before the edge, so no race with the RTL.
	always @(posedge clk) begin
		otmr_pkg::result_t got;
		if (arst_n && valid) begin
			got.status = otmr_pkg::status_t'(status);
			got.slot_index = slot_index;
			got.fired_callback = fired_callback;
			got.fired_arg = fired_arg;
			got.tick_now = tick_now;
			got.last = last;
			shadow.match_result(got);
		end
	end

	// Present one command and hold it until the table takes it. Call at a
	// rising edge; return at the edge of the transfer with start still high,
	// so that a following command can go out back to back.
	task automatic issue(otmr_pkg::cmd_t cmd, logic [31:0] cb, logic [31:0] arg,
			logic [31:0] dl, logic [3:0] h);
		start <= 1'b1;
		command <= cmd;
		callback_id <= cb;
		user_arg <= arg;
		deadline <= dl;
		slot_handle <= h;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		shadow.take_command(cmd, cb, arg, dl, h);
		if (cmd != otmr_pkg::CMD_NONE)
			issued++;
	endtask

	// Drop start for a random stretch: mostly none or short, now and then long
	task automatic idle_gap();
		int n;
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) n = 0;
		else if (r < 9) n = $urandom_range(1, 3);
		else n = $urandom_range(10, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Hold off until every awaited result has come out
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (shadow.awaited.size() != 0)
			@(posedge clk);
	endtask

	// Deadlines mostly a few ticks ahead so that timers really fire; some
	// already passed, some anywhere in the 32-bit range.
	function automatic logic [31:0] pick_deadline();
		int r;
		logic [31:0] d;
		r = $urandom_range(0, 9);
		if (r < 6) d = shadow.ticks + 32'($urandom_range(1, 4));
		else if (r < 8) d = shadow.ticks - 32'($urandom_range(0, 3));
		else if (r < 9) d = $urandom;
		else d = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
		if (d == '0) d = 32'd1;
		return d;
	endfunction

	function automatic logic [31:0] pick_callback();
		logic [31:0] c;
		c = $urandom;
		return (c == '0) ? 32'd1 : c;
	endfunction

	// One create with random content; about one in ten is malformed
	task automatic random_create();
		logic [31:0] cb;
		logic [31:0] dl;
		cb = pick_callback();
		dl = pick_deadline();
		case ($urandom_range(0, 19))
			0: cb = '0;
			1: dl = '0;
			default: ;
		endcase
		issue(otmr_pkg::CMD_CREATE, cb, $urandom, dl, 4'($urandom));
	endtask

	task automatic random_tick();
		issue(otmr_pkg::CMD_TICK, $urandom, $urandom, $urandom, 4'($urandom));
	endtask

	task automatic random_delete();
		logic [3:0] h;
		h = ($urandom_range(0, 3) != 0) ? shadow.some_used_slot() : 4'($urandom);
		issue(otmr_pkg::CMD_DELETE, $urandom, $urandom, $urandom, h);
	endtask

	// Short directed run: rejected creates, field extremes, expiry of one and
	// of several timers in one tick, delete of used and free slots, and an
	// unknown command that the table must ignore.
	task automatic directed_run();
		issue(otmr_pkg::CMD_CREATE, 32'd0, 32'h1234_5678, 32'd5, 4'd0);
		idle_gap();
		issue(otmr_pkg::CMD_CREATE, 32'hDEAD_BEEF, 32'h0, 32'd0, 4'd0);
		issue(otmr_pkg::CMD_CREATE, 32'd0, 32'hFFFF_FFFF, 32'd0, 4'hF);
		issue(otmr_pkg::CMD_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 4'hF);
		issue(otmr_pkg::CMD_CREATE, 32'd1, 32'd0, 32'hFFFF_FFFF, 4'd0);
		issue(otmr_pkg::CMD_CREATE, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'd2, 4'd0);
		issue(otmr_pkg::CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
		issue(otmr_pkg::CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
		idle_gap();
		issue(otmr_pkg::CMD_DELETE, 32'd0, 32'd0, 32'd0, 4'd0);
		issue(otmr_pkg::CMD_DELETE, 32'd0, 32'd0, 32'd0, 4'hF);
		issue(otmr_pkg::CMD_CREATE, 32'h8000_0001, 32'h7FFF_FFFE, 32'd1, 4'd0);
		issue(otmr_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, 4'd0);
		issue(otmr_pkg::CMD_DELETE, 32'd0, 32'd0, 32'd0, 4'd1);
		issue(otmr_pkg::CMD_TICK, 32'd0, 32'd0, 32'd0, 4'd0);
		issue(otmr_pkg::CMD_CREATE, 32'h0000_0100, 32'h0000_0200, 32'hFFFF_FFFE, 4'd0);
		issue(otmr_pkg::CMD_CREATE, 32'h0000_0101, 32'h0000_0201, 32'h8000_0000, 4'd0);
		issue(otmr_pkg::CMD_DELETE, 32'd0, 32'd0, 32'd0, 4'd0);
		issue(otmr_pkg::CMD_DELETE, 32'd0, 32'd0, 32'd0, 4'd1);
	endtask

	// Issue from 8 to SLOTS+3 creates, which can fill the table past full, then from 1 to 5 tick commands
	task automatic fill_run();
		int n;
		n = $urandom_range(8, SLOTS + 3);
		repeat (n) begin
			issue(otmr_pkg::CMD_CREATE, pick_callback(), $urandom,
				shadow.ticks + 32'($urandom_range(1, 3)), 4'($urandom));
			idle_gap();
		end
		repeat ($urandom_range(1, 5)) begin
			random_tick();
			idle_gap();
		end
	endtask

	task automatic mixed_run();
		int r;
		repeat ($urandom_range(5, 15)) begin
			r = $urandom_range(0, 19);
			if (r < 8) random_tick();
			else if (r < 15) random_create();
			else if (r < 19) random_delete();
			else issue(otmr_pkg::CMD_NONE, $urandom, $urandom, $urandom, 4'($urandom));
			idle_gap();
		end
	endtask

	initial begin
		issued = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_run();

		// Let the directed part drain completely before the first fill, so the
		// full-table case starts from a known, mostly empty table.
		drain();
		fill_run();
		issue(otmr_pkg::CMD_CREATE, pick_callback(), $urandom, 32'hFFFF_FFFF, 4'd0);

		while (issued < 260) begin
			case ($urandom_range(0, 9))
				0, 1: fill_run();
				2: drain();
				default: mixed_run();
			endcase
		end

		// Wait for the tail of results, then allow a full tick scan of slack
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (shadow.awaited.size() != 0) begin
			void'(shadow.awaited.pop_front());
			shadow.failures++;
			if (shadow.failures <= 10)
				$display("%t MISSING result never produced", $realtime);
		end
		if (shadow.failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Timeout: run did not finish");
		$display("Test completed with failures");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/otmr_pkg.sv
hw/rtl/otmr_cell.sv
hw/rtl/otmr_ctrl.sv
hw/rtl/one_shot_timer_table_core.sv
tb/sv/tb.sv
